>>> design/lac_pkg.sv
// ----------------------------------------------------------------------------
// Lagged autocorrelation averager package
// Shared constants, types and sequencer states for the averager block.
// ----------------------------------------------------------------------------
`default_nettype none

package lac_pkg;

    localparam int MAX_LAG = 256;
    localparam int LAG_AW  = $clog2(MAX_LAG);

    localparam logic [20:0] MAX_SAMPLES = 21'd1048576;
    localparam logic [10:0] MAX_TRAJ    = 11'd1024;
    localparam logic [8:0]  LAG_LIMIT   = 9'(MAX_LAG);

    localparam int DIV_W = 54;
    localparam int DEN_W = 21;
    localparam int DIV_CW = $clog2(DIV_W);

    // Input actions; the spare code does nothing.
    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_END  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_NOP  = 2'd3;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } sample_t;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic [DEN_W-1:0]        divisor;
    } div_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S_WR,
        ST_S_RD,
        ST_S_MUL,
        ST_S_SUM,
        ST_S_ACC,
        ST_E_RD,
        ST_E_DIV,
        ST_E_WAIT,
        ST_E_FIN,
        ST_R_RD,
        ST_R_DIV,
        ST_R_WAIT,
        ST_R_OUT
    } state_t;

endpackage

`default_nettype wire

>>> design/lac_dot.sv
// ----------------------------------------------------------------------------
// Dot product unit
// Two-stage pipelined dot product of two three-axis samples.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_dot
    import lac_pkg::*;
(
    input  wire logic               aclk,
    input  wire sample_t            a,
    input  wire sample_t            b,
    output logic signed [33:0]      sum
);

    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] pz_reg;
    logic signed [33:0] sum_reg;

    // Stage one registers the three products, stage two their sum.
    always_ff @(posedge aclk) begin
        px_reg  <= a.x * b.x;
        py_reg  <= a.y * b.y;
        pz_reg  <= a.z * b.z;
        sum_reg <= {{2{px_reg[31]}}, px_reg} + {{2{py_reg[31]}}, py_reg}
                 + {{2{pz_reg[31]}}, pz_reg};
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

>>> design/lac_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Signed by unsigned restoring division, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_div
    import lac_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire div_req_t                req,
    output logic                         done,
    output logic signed [DIV_W-1:0]      quotient
);

    logic              run_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              neg_reg;
    logic [DIV_W-1:0]  mag_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DIV_W-1:0]  quot_reg;

    logic [DEN_W:0]    trial;
    logic              fits;
    logic [DEN_W-1:0]  rem_next;
    logic [DIV_W-1:0]  mag_next;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        trial    = {rem_reg, mag_reg[DIV_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        mag_next = {mag_reg[DIV_W-2:0], fits};
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitudes are divided, the sign is restored at the end.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg <= req.dividend[DIV_W-1];
            mag_reg <= req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end else if (run_reg) begin
            rem_reg <= rem_next;
            mag_reg <= mag_next;
            if (cnt_reg == DIV_CW'(DIV_W - 1)) begin
                quot_reg <= neg_reg ? DIV_W'(-mag_next) : mag_next;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

>>> design/lagged_autocorrelation_averager.sv
// ----------------------------------------------------------------------------
// Lagged autocorrelation averager
// Adding a sample writes the history ring, then per lag below min(lags in
// use, samples so far) reads, multiplies, sums and accumulates via the shared
// dot product unit and lag sum read-modify-write. Ending a trajectory divides
// each lag sum with pairs on the 54-step shared divider, as a read does for
// one mean sum. One item at a time. Sync active-low reset clears all sums.
// ----------------------------------------------------------------------------
`default_nettype none

module lagged_autocorrelation_averager
    import lac_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [8:0]         cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_action,
    input  wire logic signed [15:0] s_dip_x,
    input  wire logic signed [15:0] s_dip_y,
    input  wire logic signed [15:0] s_dip_z,
    input  wire logic [7:0]         s_lag_index,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_lag_echo,
    output logic signed [32:0]      m_mean_corr,
    output logic                    m_has_data,
    output logic                    m_overflow
);

    state_t state_reg, state_next;

    logic [8:0]        max_lag_reg;
    logic [8:0]        lag_reg;
    logic [8:0]        lim_reg;
    logic [7:0]        wr_ptr_reg;
    logic [20:0]       sample_cnt_reg;
    logic [10:0]       traj_cnt_reg;
    logic              ovf_reg;
    sample_t           cur_reg;
    logic [7:0]        lag_idx_reg;
    logic [MAX_LAG-1:0] lag_valid_reg;
    logic [MAX_LAG-1:0] traj_valid_reg;
    logic              lag_rdv_reg;
    logic              traj_rdv_reg;
    logic signed [32:0] mean_reg;

    sample_t           hist_mem [MAX_LAG];
    logic [53:0]       lag_mem  [MAX_LAG];
    logic [43:0]       traj_mem [MAX_LAG];
    sample_t           hist_rd_reg;
    logic signed [53:0] lag_rd_reg;
    logic signed [43:0] traj_rd_reg;

    logic              m_valid_reg;
    logic [7:0]        m_lag_reg;
    logic signed [32:0] m_mean_reg;
    logic              m_has_reg;
    logic              m_ovf_reg;

    logic              accept;
    logic [8:0]        lags_in_use;
    logic [20:0]       cnt_plus1;
    logic              more_lags;
    logic [LAG_AW-1:0] lag_addr;
    logic signed [33:0] dot_sum;
    div_req_t          div_req;
    logic              div_done;
    logic signed [DIV_W-1:0] div_quot;
    logic              out_free;

    assign accept      = s_valid && s_ready;
    assign lags_in_use = (max_lag_reg == 9'd0) ? 9'd1
                       : ((max_lag_reg > LAG_LIMIT) ? LAG_LIMIT : max_lag_reg);
    assign cnt_plus1   = sample_cnt_reg + 21'd1;
    assign more_lags   = ({1'b0, lag_reg} + 10'd1) < {1'b0, lim_reg};
    assign lag_addr    = lag_reg[LAG_AW-1:0];
    assign out_free    = !m_valid_reg || m_ready;

    // Shared arithmetic units.
    lac_dot u_dot (
        .aclk (aclk),
        .a    (cur_reg),
        .b    (hist_rd_reg),
        .sum  (dot_sum)
    );

    lac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_action)
                        ACT_ADD: begin
                            if (sample_cnt_reg != MAX_SAMPLES) begin
                                state_next = ST_S_WR;
                            end
                        end
                        ACT_END: begin
                            if (traj_cnt_reg != MAX_TRAJ && sample_cnt_reg != 21'd0) begin
                                state_next = ST_E_RD;
                            end else begin
                                state_next = ST_E_FIN;
                            end
                        end
                        ACT_READ: begin
                            state_next = (traj_cnt_reg == 11'd0) ? ST_R_OUT : ST_R_RD;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_S_WR:   state_next = ST_S_RD;
            ST_S_RD:   state_next = ST_S_MUL;
            ST_S_MUL:  state_next = ST_S_SUM;
            ST_S_SUM:  state_next = ST_S_ACC;
            ST_S_ACC:  state_next = more_lags ? ST_S_RD : ST_IDLE;
            ST_E_RD:   state_next = ST_E_DIV;
            ST_E_DIV:  state_next = ST_E_WAIT;
            ST_E_WAIT: begin
                if (div_done) begin
                    state_next = more_lags ? ST_E_RD : ST_E_FIN;
                end
            end
            ST_E_FIN:  state_next = ST_IDLE;
            ST_R_RD:   state_next = ST_R_DIV;
            ST_R_DIV:  state_next = ST_R_WAIT;
            ST_R_WAIT: begin
                if (div_done) begin
                    state_next = ST_R_OUT;
                end
            end
            ST_R_OUT:  state_next = out_free ? ST_IDLE : ST_R_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Handshake and divider request.
    always_comb begin
        s_ready          = (state_reg == ST_IDLE);
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            ST_E_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = lag_rdv_reg ? lag_rd_reg : '0;
                div_req.divisor  = sample_cnt_reg - {12'd0, lag_reg};
            end
            ST_R_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = traj_rdv_reg
                                 ? {{(DIV_W-44){traj_rd_reg[43]}}, traj_rd_reg} : '0;
                div_req.divisor  = {10'd0, traj_cnt_reg};
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            max_lag_reg    <= LAG_LIMIT;
            wr_ptr_reg     <= '0;
            sample_cnt_reg <= '0;
            traj_cnt_reg   <= '0;
            ovf_reg        <= 1'b0;
            lag_valid_reg  <= '0;
            traj_valid_reg <= '0;
            lag_reg        <= '0;
            lim_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                max_lag_reg <= cfg_wr_data;
            end
            case (state_reg)
                ST_IDLE: begin
                    lag_reg <= '0;
                    if (accept && s_action == ACT_ADD && sample_cnt_reg == MAX_SAMPLES) begin
                        ovf_reg <= 1'b1;
                    end
                    if (accept && s_action == ACT_END) begin
                        lim_reg <= (sample_cnt_reg < {12'd0, lags_in_use})
                                 ? sample_cnt_reg[8:0] : lags_in_use;
                    end
                end
                ST_S_WR: begin
                    lim_reg <= (cnt_plus1 < {12'd0, lags_in_use})
                             ? cnt_plus1[8:0] : lags_in_use;
                end
                ST_S_ACC: begin
                    lag_valid_reg[lag_addr] <= 1'b1;
                    lag_reg <= lag_reg + 9'd1;
                    if (!more_lags) begin
                        wr_ptr_reg     <= wr_ptr_reg + 8'd1;
                        sample_cnt_reg <= cnt_plus1;
                    end
                end
                ST_E_WAIT: begin
                    if (div_done) begin
                        traj_valid_reg[lag_addr] <= 1'b1;
                        lag_reg <= lag_reg + 9'd1;
                    end
                end
                ST_E_FIN: begin
                    lag_valid_reg  <= '0;
                    sample_cnt_reg <= '0;
                    wr_ptr_reg     <= '0;
                    if (traj_cnt_reg != MAX_TRAJ) begin
                        traj_cnt_reg <= traj_cnt_reg + 11'd1;
                    end
                end
                default: begin
                    lag_reg <= lag_reg;
                end
            endcase
        end
    end

    // Captured request fields and the mean of a read.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && accept) begin
            cur_reg.x   <= s_dip_x;
            cur_reg.y   <= s_dip_y;
            cur_reg.z   <= s_dip_z;
            lag_idx_reg <= s_lag_index;
            mean_reg    <= '0;
        end else if (state_reg == ST_R_WAIT && div_done) begin
            mean_reg <= div_quot[32:0];
        end
    end

    // Sample history ring.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_S_WR) begin
            hist_mem[wr_ptr_reg] <= cur_reg;
        end
        if (state_reg == ST_S_RD) begin
            hist_rd_reg <= hist_mem[wr_ptr_reg - lag_addr];
        end
    end

    // Per-trajectory lag sums; an entry without its valid bit reads as zero.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_S_ACC) begin
            lag_mem[lag_addr] <= (lag_rdv_reg ? lag_rd_reg : 54'sd0)
                               + {{20{dot_sum[33]}}, dot_sum};
        end
        if (state_reg == ST_S_RD || state_reg == ST_E_RD) begin
            lag_rd_reg  <= lag_mem[lag_addr];
            lag_rdv_reg <= lag_valid_reg[lag_addr];
        end
    end

    // Sums of per-trajectory means.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_E_WAIT && div_done) begin
            traj_mem[lag_addr] <= (traj_rdv_reg ? traj_rd_reg : 44'sd0) + div_quot[43:0];
        end
        if (state_reg == ST_E_RD) begin
            traj_rd_reg  <= traj_mem[lag_addr];
            traj_rdv_reg <= traj_valid_reg[lag_addr];
        end else if (state_reg == ST_R_RD) begin
            traj_rd_reg  <= traj_mem[lag_idx_reg];
            traj_rdv_reg <= traj_valid_reg[lag_idx_reg];
        end
    end

    // Output register: holds a result until its transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_R_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_R_OUT && out_free) begin
            m_lag_reg  <= lag_idx_reg;
            m_mean_reg <= mean_reg;
            m_has_reg  <= (traj_cnt_reg != 11'd0);
            m_ovf_reg  <= ovf_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_lag_echo  = m_lag_reg;
    assign m_mean_corr = m_mean_reg;
    assign m_has_data  = m_has_reg;
    assign m_overflow  = m_ovf_reg;

endmodule

`default_nettype wire
